@@ rtl/rist_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request identifier slot table: shared definitions
// Operation and status codes, field widths and the index width helper.
// ----------------------------------------------------------------------------
package rist_pkg;

   localparam int SLOT_COUNT_DEFAULT = 20;
   localparam int KIND_W             = 2;
   localparam int SLOT_W             = 5;
   localparam int HALF_W             = 64;
   localparam int ID_W               = 2 * HALF_W;
   localparam int STATUS_W           = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOCATE = 2'd0,
      KIND_FREE     = 2'd1,
      KIND_SET_ID   = 2'd2,
      KIND_SEARCH   = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   // index width for a table of the given depth, at least one bit
   function automatic int idx_width(input int depth);
      int w;
      w = $clog2(depth);
      return (w < 1) ? 1 : w;
   endfunction

endpackage

@@ rtl/rist_id_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Identifier store
// One-write, one-read synchronous memory of 128-bit identifiers with a
// registered read; unwritten entries read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module rist_id_mem import rist_pkg::*; #(
   parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT,
   parameter int IDX_W      = idx_width(SLOT_COUNT)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [ID_W-1:0]  wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [ID_W-1:0]  rd_data
);

   logic [ID_W-1:0]       mem_q [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] valid_ff;
   logic [ID_W-1:0]       rd_data_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_q[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ rtl/rist_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table sequencer
// Holds the used marks, walks the slots for allocate and search, drives the
// identifier store and issues one response per request.
// ----------------------------------------------------------------------------
module rist_ctrl import rist_pkg::*; #(
   parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT,
   parameter int IDX_W      = idx_width(SLOT_COUNT)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [HALF_W-1:0]   req_id_high,
   input  logic [HALF_W-1:0]   req_id_low,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_result_slot,
   output logic                wr_en,
   output logic [IDX_W-1:0]    wr_addr,
   output logic [ID_W-1:0]     wr_data,
   output logic                rd_en,
   output logic [IDX_W-1:0]    rd_addr,
   input  logic [ID_W-1:0]     rd_data
);

   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_ALLOC  = 3'b010,
      ST_SEARCH = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]      chk_idx_ff, chk_idx_in;
   logic [ID_W-1:0]       key_ff, key_in;
   logic [SLOT_COUNT-1:0] used_ff, used_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;

   logic [6:0]       slot_ext;
   logic [IDX_W-1:0] req_idx;
   logic             req_in_range;
   logic [IDX_W-1:0] cnt_idx;
   logic             scan_more;

   assign slot_ext     = 7'(req_slot);
   assign req_idx      = slot_ext[IDX_W-1:0];
   assign req_in_range = slot_ext < 7'(SLOT_COUNT);
   assign cnt_idx      = cnt_ff[IDX_W-1:0];
   assign scan_more    = cnt_ff < CNT_W'(SLOT_COUNT);

   assign wr_addr = req_idx;
   assign wr_data = {req_id_high, req_id_low};
   assign rd_addr = cnt_idx;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      key_in        = key_ff;
      used_in       = used_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (kind_type'(req_kind))
                  KIND_ALLOCATE: begin
                     cnt_in   = '0;
                     state_in = ST_ALLOC;
                  end
                  KIND_FREE: begin
                     if (req_in_range) begin
                        used_in[req_idx] = 1'b0;
                     end
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STATUS_OK;
                     rsp_slot_in   = '0;
                  end
                  KIND_SET_ID: begin
                     wr_en         = req_in_range;
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STATUS_OK;
                     rsp_slot_in   = '0;
                  end
                  KIND_SEARCH: begin
                     key_in   = {req_id_high, req_id_low};
                     cnt_in   = '0;
                     state_in = ST_SEARCH;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ALLOC: begin
            if (!used_ff[cnt_idx]) begin
               used_in[cnt_idx] = 1'b1;
               rsp_strobe_in    = 1'b1;
               rsp_status_in    = STATUS_OK;
               rsp_slot_in      = SLOT_W'(cnt_idx);
               state_in         = ST_IDLE;
            end else if (cnt_idx == LAST_IDX) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_FULL;
               rsp_slot_in   = '0;
               state_in      = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_SEARCH: begin
            // issue the next read while the previous entry is compared
            rd_en = scan_more;
            if (scan_more) begin
               cnt_in     = cnt_ff + CNT_W'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = cnt_idx;
            end
            if (chk_vld_ff) begin
               if (used_ff[chk_idx_ff] && (rd_data == key_ff)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STATUS_OK;
                  rsp_slot_in   = SLOT_W'(chk_idx_ff);
                  chk_vld_in    = 1'b0;
                  state_in      = ST_IDLE;
               end else if (chk_idx_ff == LAST_IDX) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STATUS_NOT_FOUND;
                  rsp_slot_in   = '0;
                  chk_vld_in    = 1'b0;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         chk_vld_ff    <= 1'b0;
         used_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         chk_vld_ff    <= chk_vld_in;
         used_ff       <= used_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      chk_idx_ff    <= chk_idx_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_slot = rsp_slot_ff;

endmodule

@@ rtl/request_id_slot_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request identifier slot table
// Table of SLOT_COUNT slots, each with a used mark and a 128-bit identifier:
// allocate lowest free slot, free, set identifier, search by identifier.
//
// Usage:
//  - Request: drive req_kind, req_slot, req_id_high and req_id_low with start
//    high; the request is taken at the edge where start is high and busy low.
//  - Response: rsp_status and rsp_result_slot are valid for exactly one cycle
//    while rsp_strobe is high; the receiver must take them then.
//  - Timing: free and set identifier answer in the cycle after acceptance and
//    leave busy low, so a new request may follow at once. Allocate walks the
//    used marks one slot per cycle. Search reads the identifier memory one
//    entry per cycle through its registered read port. Busy is high throughout
//    either walk.
//  - Issue: a new request is taken only after an allocate or search walk ends;
//    free and set identifier leave busy low and do not hold the next request.
//  - Reset: all used marks clear and every identifier reads as zero; no
//    clearing pass is needed, requests are taken from the first cycle.
//  - The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
module request_id_slot_table import rist_pkg::*; #(
   parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [HALF_W-1:0]   req_id_high,
   input  logic [HALF_W-1:0]   req_id_low,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_result_slot
);

   localparam int IDX_W = idx_width(SLOT_COUNT);

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [ID_W-1:0]  wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [ID_W-1:0]  rd_data;

   rist_ctrl #(
      .SLOT_COUNT (SLOT_COUNT),
      .IDX_W      (IDX_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_slot        (req_slot),
      .req_id_high     (req_id_high),
      .req_id_low      (req_id_low),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_result_slot (rsp_result_slot),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data)
   );

   rist_id_mem #(
      .SLOT_COUNT (SLOT_COUNT),
      .IDX_W      (IDX_W)
   ) u_id_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request identifier slot table testbench
// Drives allocate, free, set identifier and search requests through the
// start/busy port and predicts every response from a private copy of the used
// marks and identifiers. Directed requests cover the corner cases. Random
// phases with varying allocate pressure fill and drain the table, and the
// sender idles at several rates. Each strobed response is checked in order.
// ----------------------------------------------------------------------------
module tb import rist_pkg::*; ();

   localparam int SLOTS      = SLOT_COUNT_DEFAULT;
   localparam int HALF_PERIOD_PS = 6000;
   localparam int STALL_LIMIT = 500;
   localparam int RANDOM_PER_PHASE = 232;

   typedef struct {
      kind_type             kind;
      status_type           status;
      logic [SLOT_W-1:0]    slot;
   } reply_type;

   class slot_table_scoreboard;
      bit                used [SLOTS];
      logic [HALF_W-1:0] tag_high [SLOTS];
      logic [HALF_W-1:0] tag_low [SLOTS];
      reply_type         expected_replies [$];
      int                errors;
      int                requests;
      int                kind_seen [4];
      int                full_seen;
      int                miss_seen;
      int                hit_seen;
      int                outside_seen;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            used[i]     = 1'b0;
            tag_high[i] = '0;
            tag_low[i]  = '0;
         end
         errors = 0;
         requests = 0;
         full_seen = 0;
         miss_seen = 0;
         hit_seen = 0;
         outside_seen = 0;
         for (int i = 0; i < 4; i++) kind_seen[i] = 0;
      endfunction

      function reply_type predict_reply(kind_type k, logic [SLOT_W-1:0] s,
                                        logic [HALF_W-1:0] h, logic [HALF_W-1:0] l);
         reply_type r;
         r.kind   = k;
         r.status = STATUS_OK;
         r.slot   = '0;
         case (k)
            KIND_ALLOCATE: begin
               r.status = STATUS_FULL;
               for (int i = 0; i < SLOTS; i++) begin
                  if (!used[i]) begin
                     used[i]  = 1'b1;
                     r.status = STATUS_OK;
                     r.slot   = i[SLOT_W-1:0];
                     break;
                  end
               end
            end
            KIND_FREE: begin
               if (s < SLOTS) used[s] = 1'b0;
            end
            KIND_SET_ID: begin
               if (s < SLOTS) begin
                  tag_high[s] = h;
                  tag_low[s]  = l;
               end
            end
            default: begin
               r.status = STATUS_NOT_FOUND;
               for (int i = 0; i < SLOTS; i++) begin
                  if (used[i] && tag_high[i] == h && tag_low[i] == l) begin
                     r.status = STATUS_OK;
                     r.slot   = i[SLOT_W-1:0];
                     break;
                  end
               end
            end
         endcase
         return r;
      endfunction

      function void note_request(kind_type k, logic [SLOT_W-1:0] s,
                                 logic [HALF_W-1:0] h, logic [HALF_W-1:0] l);
         reply_type r;
         r = predict_reply(k, s, h, l);
         requests++;
         kind_seen[k]++;
         if (k == KIND_ALLOCATE && r.status == STATUS_FULL) full_seen++;
         if (k == KIND_SEARCH && r.status == STATUS_NOT_FOUND) miss_seen++;
         if (k == KIND_SEARCH && r.status == STATUS_OK) hit_seen++;
         if ((k == KIND_FREE || k == KIND_SET_ID) && s >= SLOTS) outside_seen++;
         expected_replies.push_back(r);
      endfunction

      function void check_response(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] s);
         reply_type r;
         if (expected_replies.size() == 0) begin
            $display("%0t: unexpected response status %0d slot %0d", $time, st, s);
            errors++;
            return;
         end
         r = expected_replies.pop_front();
         if (st !== r.status) begin
            $display("%0t: %s status expected %0d actual %0d",
                     $time, r.kind.name(), r.status, st);
            errors++;
         end
         if (s !== r.slot) begin
            $display("%0t: %s result_slot expected %0d actual %0d",
                     $time, r.kind.name(), r.slot, s);
            errors++;
         end
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [KIND_W-1:0]   req_kind;
   logic [SLOT_W-1:0]   req_slot;
   logic [HALF_W-1:0]   req_id_high;
   logic [HALF_W-1:0]   req_id_low;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_result_slot;

   slot_table_scoreboard sb;
   int                   accepted;
   int                   quiet_cycles;
   int                   idle_pct;
   int                   alloc_bias;
   logic [ID_W-1:0]      id_pool [8];

   request_id_slot_table #(.SLOT_COUNT(SLOTS)) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_slot        (req_slot),
      .req_id_high     (req_id_high),
      .req_id_low      (req_id_low),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_result_slot (rsp_result_slot)
   );

   always #(HALF_PERIOD_PS * 1ps) clock = ~clock;

   // check before noting: a response at this edge belongs to an earlier request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) sb.check_response(rsp_status, rsp_result_slot);
         if (start && !busy) begin
            sb.note_request(kind_type'(req_kind), req_slot, req_id_high, req_id_low);
            accepted++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [HALF_W-1:0] rand_half();
      return {$urandom, $urandom};
   endfunction

   task automatic issue_request(input kind_type k, input logic [SLOT_W-1:0] s,
                                input logic [HALF_W-1:0] h, input logic [HALF_W-1:0] l);
      int gap;
      int taken;
      gap = 0;
      while (gap < 30 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_kind    = k;
      req_slot    = s;
      req_id_high = h;
      req_id_low  = l;
      start       = 1'b1;
      taken       = accepted;
      while (accepted == taken) @(negedge clock);
   endtask

   task automatic drain_replies();
      start = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic run_directed();
      logic [HALF_W-1:0] ones;
      logic [HALF_W-1:0] pat;
      ones = '1;
      pat  = 64'hA5A5_5A5A_0F0F_F0F0;
      issue_request(KIND_SEARCH, 5'd0, '0, '0);
      issue_request(KIND_SET_ID, 5'd0, ones, ones);
      issue_request(KIND_SET_ID, 5'd19, pat, ~pat);
      issue_request(KIND_SET_ID, 5'd31, pat, pat);
      issue_request(KIND_SET_ID, 5'd20, ones, '0);
      issue_request(KIND_FREE, 5'd20, '0, '0);
      issue_request(KIND_FREE, 5'd31, ones, ones);
      issue_request(KIND_FREE, 5'd5, '0, '0);
      issue_request(KIND_SEARCH, 5'd0, ones, ones);
      issue_request(KIND_ALLOCATE, 5'd31, ones, ones);
      issue_request(KIND_SEARCH, 5'd0, ones, ones);
      issue_request(KIND_SEARCH, 5'd0, ones, ~ones);
      issue_request(KIND_SEARCH, 5'd0, ~ones, ones);
      issue_request(KIND_ALLOCATE, 5'd0, '0, '0);
      issue_request(KIND_SEARCH, 5'd0, '0, '0);
      issue_request(KIND_SET_ID, 5'd1, ones, ones);
      issue_request(KIND_SEARCH, 5'd0, ones, ones);
      issue_request(KIND_FREE, 5'd0, '0, '0);
      issue_request(KIND_SEARCH, 5'd0, ones, ones);
      issue_request(KIND_FREE, 5'd0, '0, '0);
      issue_request(KIND_ALLOCATE, 5'd0, '0, '0);
      issue_request(KIND_SEARCH, 5'd0, ones, ones);
      issue_request(KIND_SET_ID, 5'd19, '0, '0);
      issue_request(KIND_SEARCH, 5'd0, pat, ~pat);
   endtask

   task automatic random_request();
      int               r;
      int               pick;
      logic [SLOT_W-1:0] s;
      logic [ID_W-1:0]  id;
      r  = $urandom_range(99);
      s  = ($urandom_range(4) == 0) ? SLOT_W'($urandom_range(31))
                                    : SLOT_W'($urandom_range(SLOTS - 1));
      id = id_pool[$urandom_range(7)];
      if (r < alloc_bias) begin
         issue_request(KIND_ALLOCATE, SLOT_W'($urandom_range(31)), rand_half(), rand_half());
      end else begin
         pick = $urandom_range(9);
         if (pick < 3) begin
            issue_request(KIND_FREE, s, rand_half(), rand_half());
         end else if (pick < 6) begin
            if ($urandom_range(9) == 0) id = {rand_half(), rand_half()};
            issue_request(KIND_SET_ID, s, id[ID_W-1:HALF_W], id[HALF_W-1:0]);
         end else begin
            r = $urandom_range(9);
            if (r < 2) id[$urandom_range(ID_W - 1)] ^= 1'b1;
            else if (r < 3) id = {rand_half(), rand_half()};
            issue_request(KIND_SEARCH, s, id[ID_W-1:HALF_W], id[HALF_W-1:0]);
         end
      end
      if ($urandom_range(49) == 0) id_pool[2 + $urandom_range(5)] = {rand_half(), rand_half()};
   endtask

   task automatic run_phase(input int pct, input bit hold_once);
      idle_pct = pct;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(2))
               0: alloc_bias = 15;
               1: alloc_bias = 40;
               default: alloc_bias = 70;
            endcase
         end
         if (hold_once && n == RANDOM_PER_PHASE / 2) drain_replies();
         random_request();
      end
      drain_replies();
   endtask

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      start        = 1'b0;
      req_kind     = '0;
      req_slot     = '0;
      req_id_high  = '0;
      req_id_low   = '0;
      accepted     = 0;
      quiet_cycles = 0;
      idle_pct     = 0;
      alloc_bias   = 40;
      sb           = new();
      id_pool[0]   = '0;
      id_pool[1]   = '1;
      id_pool[2]   = {rand_half(), rand_half()};
      id_pool[3]   = {id_pool[2][ID_W-1:HALF_W], rand_half()};
      id_pool[4]   = {rand_half(), rand_half()};
      id_pool[5]   = {rand_half(), id_pool[4][HALF_W-1:0]};
      id_pool[6]   = {rand_half(), rand_half()};
      id_pool[7]   = ~id_pool[6];
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();
      drain_replies();
      run_phase(0, 1'b1);
      run_phase(69, 1'b0);
      run_phase(0, 1'b0);
      run_phase(16, 1'b1);

      start = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SLOTS + 5) @(negedge clock);

      $display("covered %0d requests: %0d allocate, %0d free, %0d set, %0d search",
               sb.requests, sb.kind_seen[KIND_ALLOCATE], sb.kind_seen[KIND_FREE],
               sb.kind_seen[KIND_SET_ID], sb.kind_seen[KIND_SEARCH]);
      $display("table full %0d times, search hits %0d, misses %0d, slot out of range %0d",
               sb.full_seen, sb.hit_seen, sb.miss_seen, sb.outside_seen);
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
